// File: hw/rtl/gsnf_pkg.sv
// Shared types and constants for the safe node finder.
package gsnf_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_SOLVE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_ROOT,
    ST_ROWRD,
    ST_SCAN,
    ST_STKRD,
    ST_EMIT
  } state_e;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;

  typedef struct packed {
    logic clr_graph;
    logic edge_load;
    logic edge_wr;
    logic solve_init;
    logic root_step;
    logic row_load;
    logic scan;
    logic top_load;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic root_push;
    logic roots_done;
    logic scan_push;
    logic scan_fail;
    logic scan_pop;
    logic pop_last;
    logic emit_last;
  } stat_t;

endpackage

// File: hw/rtl/gsnf_if.sv
// Valid/ready channel interfaces for input items and results.
interface gsnf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] source_node;
  logic [5:0] target_node;
  modport source (output valid, kind, source_node, target_node, input ready);
  modport sink (input valid, kind, source_node, target_node, output ready);
endinterface

interface gsnf_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] node_index;
  logic       is_safe;
  logic       last;
  modport source (output valid, node_index, is_safe, last, input ready);
  modport sink (input valid, node_index, is_safe, last, output ready);
endinterface

// File: hw/rtl/gsnf_ram.sv
// Generic single-port-write, registered-read RAM.
module gsnf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hw/rtl/gsnf_datapath.sv
// Datapath: adjacency memory, marks, walk stack and result register.
module gsnf_datapath import gsnf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [NODE_W-1:0]  src_i,
  input  logic [NODE_W-1:0]  dst_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [NODE_W-1:0]  out_index_o,
  output logic               out_safe_o,
  output logic               out_last_o
);
  localparam int SW = NODE_W + COUNT_W;

  logic [COUNT_W-1:0] n;

  // row memory signals; rows without a valid bit read as empty
  logic                 row_we;
  logic [NODE_W-1:0]    row_waddr, row_raddr;
  logic [MAX_NODES-1:0] row_wdata, row_rdata, row_eff;

  // stack memory: node, next successor
  logic              stk_we;
  logic [NODE_W-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0]     stk_wdata, stk_rdata;

  logic [MAX_NODES-1:0] rowv_q, vis_q, onp_q, safe_q, row_q;
  logic                 rowv_rd_q;
  logic [NODE_W-1:0]    src_q, dst_q, cur_q;
  logic [COUNT_W-1:0]   j_q, depth_q, root_q, emit_q;
  logic                 ovalid_q, osafe_q, olast_q;
  logic [NODE_W-1:0]    oidx_q;

  logic [NODE_W-1:0] v;
  logic in_range, has_edge, do_push, do_fail, do_pop, do_root, edge_ok;

  always_comb begin
    if (count_i == '0) n = COUNT_W'(1);
    else if (count_i > COUNT_W'(MAX_NODES)) n = COUNT_W'(MAX_NODES);
    else n = count_i;
  end

  gsnf_ram #(.Width(MAX_NODES), .Depth(MAX_NODES)) u_rows (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(row_raddr), .rdata_o(row_rdata)
  );
  gsnf_ram #(.Width(SW), .Depth(MAX_NODES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // scan step over the current row, one candidate per cycle
  assign v        = j_q[NODE_W-1:0];
  assign in_range = j_q < n;
  assign has_edge = in_range && row_q[v];
  assign do_push  = cmd_i.scan && has_edge && !vis_q[v];
  assign do_fail  = cmd_i.scan && has_edge && vis_q[v] && onp_q[v];
  assign do_pop   = cmd_i.scan && !in_range;
  assign do_root  = cmd_i.root_step && root_q < n && !vis_q[root_q[NODE_W-1:0]];
  assign edge_ok  = {1'b0, src_q} < n && {1'b0, dst_q} < n;

  assign row_eff = rowv_rd_q ? row_rdata : '0;

  always_comb begin
    row_raddr = src_i;
    if (cmd_i.root_step) row_raddr = root_q[NODE_W-1:0];
    if (cmd_i.scan)      row_raddr = v;
    if (cmd_i.top_load)  row_raddr = stk_rdata[SW-1:COUNT_W];
  end
  assign row_we    = cmd_i.edge_wr && edge_ok;
  assign row_waddr = src_q;
  assign row_wdata = row_eff | (MAX_NODES'(1) << dst_q);

  // the top entry lives in cur_q/j_q; a push saves the parent below it
  assign stk_we    = do_push;
  assign stk_waddr = NODE_W'(depth_q - COUNT_W'(1));
  assign stk_wdata = {cur_q, j_q + COUNT_W'(1)};
  assign stk_raddr = NODE_W'(depth_q - COUNT_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q   <= '0;
      vis_q    <= '0;
      onp_q    <= '0;
      safe_q   <= '0;
      depth_q  <= '0;
      root_q   <= '0;
      emit_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_graph) rowv_q <= '0;
      if (row_we) rowv_q[src_q] <= 1'b1;
      if (cmd_i.solve_init) begin
        vis_q   <= '0;
        onp_q   <= '0;
        safe_q  <= '0;
        depth_q <= '0;
        root_q  <= '0;
        emit_q  <= '0;
      end
      if (cmd_i.root_step) begin
        root_q <= root_q + COUNT_W'(1);
        if (do_root) begin
          vis_q[root_q[NODE_W-1:0]] <= 1'b1;
          onp_q[root_q[NODE_W-1:0]] <= 1'b1;
          depth_q <= COUNT_W'(1);
        end
      end
      if (do_push) begin
        vis_q[v] <= 1'b1;
        onp_q[v] <= 1'b1;
        depth_q  <= depth_q + COUNT_W'(1);
      end
      if (do_fail) depth_q <= '0;
      if (do_pop) begin
        safe_q[cur_q] <= 1'b1;
        onp_q[cur_q]  <= 1'b0;
        depth_q       <= depth_q - COUNT_W'(1);
      end
      if (cmd_i.emit_step) begin
        ovalid_q <= 1'b1;
        emit_q   <= emit_q + COUNT_W'(1);
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rowv_rd_q <= rowv_q[row_raddr];
    if (cmd_i.edge_load) begin
      src_q <= src_i;
      dst_q <= dst_i;
    end
    if (do_root) begin
      cur_q <= root_q[NODE_W-1:0];
      j_q   <= '0;
    end
    if (cmd_i.row_load) row_q <= row_eff;
    if (cmd_i.scan) begin
      if (do_push) begin
        cur_q <= v;
        j_q   <= '0;
      end else if (!do_pop && !do_fail) begin
        j_q <= j_q + COUNT_W'(1);
      end
    end
    if (cmd_i.top_load) begin
      cur_q <= stk_rdata[SW-1:COUNT_W];
      j_q   <= stk_rdata[COUNT_W-1:0];
    end
    if (cmd_i.emit_step) begin
      oidx_q  <= emit_q[NODE_W-1:0];
      osafe_q <= safe_q[emit_q[NODE_W-1:0]];
      olast_q <= (emit_q + COUNT_W'(1)) == n;
    end
  end

  assign stat_o.root_push  = do_root;
  assign stat_o.roots_done = root_q >= n;
  assign stat_o.scan_push  = do_push;
  assign stat_o.scan_fail  = do_fail;
  assign stat_o.scan_pop   = do_pop;
  assign stat_o.pop_last   = depth_q == COUNT_W'(1);
  assign stat_o.emit_last  = emit_q == n - COUNT_W'(1);

  assign out_valid_o = ovalid_q;
  assign out_index_o = oidx_q;
  assign out_safe_o  = osafe_q;
  assign out_last_o  = olast_q;
endmodule

// File: hw/rtl/gsnf_ctrl.sv
// Controller state machine sequencing clear, load, walk and report.
module gsnf_ctrl import gsnf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  kind_e kind_i,
  output logic  in_ready_o,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;
  logic   take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  assign take = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (kind_i)
            KIND_EDGE:  state_d = ST_EDGE;
            KIND_SOLVE: state_d = ST_ROOT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE: state_d = ST_IDLE;
      ST_ROOT: begin
        if (stat_i.root_push) state_d = ST_ROWRD;
        else if (stat_i.roots_done) state_d = ST_EMIT;
      end
      ST_ROWRD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (stat_i.scan_push) state_d = ST_ROWRD;
        else if (stat_i.scan_fail) state_d = ST_ROOT;
        else if (stat_i.scan_pop) state_d = stat_i.pop_last ? ST_ROOT : ST_STKRD;
      end
      ST_STKRD: state_d = ST_ROWRD;
      ST_EMIT: if (out_free_i && stat_i.emit_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.clr_graph  = take && kind_i == KIND_CLEAR;
        cmd_o.edge_load  = take && kind_i == KIND_EDGE;
        cmd_o.solve_init = take && kind_i == KIND_SOLVE;
      end
      ST_EDGE:  cmd_o.edge_wr = 1'b1;
      ST_ROOT:  cmd_o.root_step = 1'b1;
      ST_ROWRD: cmd_o.row_load = 1'b1;
      ST_SCAN:  cmd_o.scan = 1'b1;
      ST_STKRD: cmd_o.top_load = 1'b1;
      ST_EMIT:  cmd_o.emit_step = out_free_i;
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/graph_safe_node_finder_unit.sv
// Top level of the eventually safe node finder.
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      kind, source_node, target_node
//  out_ch   out  valid/ready      node_index, is_safe, last
//  apb      in   psel/penable     node_count at address 0
// Clear and unknown kind: handled on acceptance in idle. Add edge: row read, then write.
// Solve: root candidates are tried in turn; entering a node costs a push, then a row read;
// each successor is scanned in turn; a pop that resumes a parent adds a stack read and a
// row read. Then one result per cycle while the consumer takes them.
// Reset clears row valid bits (empty graph), marks and depth; node_count resets to 64.
module graph_safe_node_finder_unit import gsnf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gsnf_in_if.sink     in_ch,
  gsnf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cmd_t  cmd;
  stat_t stat;
  logic [COUNT_W-1:0] count_q;
  logic out_free;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= COUNT_W'(MAX_NODES);
    else if (psel && penable && pwrite && paddr == REG_NODE_COUNT)
      count_q <= pwdata[COUNT_W-1:0];
  end
  assign prdata = (paddr == REG_NODE_COUNT) ? 32'(count_q) : 32'd0;

  assign out_free = !out_ch.valid || out_ch.ready;

  gsnf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .kind_i(kind_e'(in_ch.kind)),
    .in_ready_o(in_ch.ready), .out_free_i(out_free), .stat_i(stat), .cmd_o(cmd)
  );

  gsnf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .src_i(in_ch.source_node), .dst_i(in_ch.target_node),
    .count_i(count_q), .out_ready_i(out_ch.ready),
    .out_valid_o(out_ch.valid), .out_index_o(out_ch.node_index),
    .out_safe_o(out_ch.is_safe), .out_last_o(out_ch.last)
  );

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=>
      $stable({out_ch.node_index, out_ch.is_safe, out_ch.last}))
    else $error("result changed while waiting");
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan |-> !in_ch.ready) else $error("input taken during walk");
`endif
endmodule
